/* hdl/dbs_pkg.sv */
// Package for the deque and bag store: default sizes, request codes,
// status codes and the sequencer state type.
// Has no dependencies; every other file of the block uses it.
package dbs_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int PORT_W   = 32;

  // Request codes; codes six and seven are undefined and change nothing.
  localparam logic [FUNC_W-1:0] FUNC_ADD_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REM_FRONT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REM_BACK  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CONTAINS  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_REM_VALUE = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_REPORT
  } dbs_state_e;

endpackage

/* hdl/deque_bag_store_unit.sv */
// Top level of the deque and bag store: request sequencer, state registers
// and output register. Uses dbs_pkg, dbs_slot and dbs_ram.
//
//  Channel   Handshake                   Payload
//  --------  --------------------------  ---------------------------------------
//  request   in_valid_i  / in_stall_o    func_i, item_value_i
//  result    out_valid_o / out_stall_i   status_o, found_o, front_value_o,
//                                        back_value_o, is_empty_o, entry_count_o
//
// One request is in work at a time; in_stall_o is high from acceptance until the
// result is loaded. Each request passes EXEC, RD_FRONT, RD_BACK and REPORT;
// RD_BACK is skipped when the store is left empty. The single RAM read port
// reads each scanned or moved entry once. Reset clears the state, head, count,
// pending and output valid flags only. A stalled result is held in the output
// register while the next request starts.
module deque_bag_store_unit #(
  parameter int CAPACITY    = dbs_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = dbs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dbs_pkg::FUNC_W-1:0]      func_i,
  input  logic signed [dbs_pkg::PORT_W-1:0] item_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dbs_pkg::STATUS_W-1:0]    status_o,
  output logic                            found_o,
  output logic signed [dbs_pkg::PORT_W-1:0] front_value_o,
  output logic signed [dbs_pkg::PORT_W-1:0] back_value_o,
  output logic                            is_empty_o,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count_o
);

  import dbs_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VW    = VALUE_WIDTH;
  localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

  dbs_state_e state_q, state_d;

  logic [FUNC_W-1:0]   func_q;
  logic [VW-1:0]       val_q, val_in;
  logic [IDX_W-1:0]    head_q, head_d, head_dec, head_inc;
  logic [CNT_W-1:0]    occ_q, occ_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    wr_q, wr_d;
  logic                pend_q, pend_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                found_q, found_d;
  logic [VW-1:0]       front_q, front_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_found_q;
  logic [PORT_W-1:0]   out_front_q, out_back_q;
  logic                out_empty_q;
  logic [CNT_W-1:0]    out_count_q;
  logic                load_out;
  logic [PORT_W-1:0]   front_ext, back_ext;

  logic                accept;
  logic                ram_we, ram_re, waddr_head;
  logic [CNT_W-1:0]    rd_pos, wr_pos;
  logic [IDX_W-1:0]    rd_slot, wr_slot, ram_waddr;
  logic [VW-1:0]       ram_wdata, ram_rdata;
  logic                match;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Values are held at VALUE_WIDTH bits and reported sign-extended, or truncated when wider, to the ports.
  generate
    if (VW >= PORT_W) begin : g_wide
      assign val_in    = VW'(item_value_i);
      assign front_ext = front_q[PORT_W-1:0];
      assign back_ext  = ram_rdata[PORT_W-1:0];
    end else begin : g_narrow
      assign val_in    = item_value_i[VW-1:0];
      assign front_ext = {{(PORT_W-VW){front_q[VW-1]}}, front_q};
      assign back_ext  = {{(PORT_W-VW){ram_rdata[VW-1]}}, ram_rdata};
    end
  endgenerate

  assign head_dec = (head_q == '0) ? LAST_IX : (head_q - 1'b1);
  assign head_inc = (head_q == LAST_IX) ? '0 : (head_q + 1'b1);
  assign match    = pend_q && (ram_rdata == val_q);

  dbs_slot #(.CAPACITY(CAPACITY)) u_rd_slot (
    .head_i (head_q),
    .pos_i  (rd_pos),
    .slot_o (rd_slot)
  );

  dbs_slot #(.CAPACITY(CAPACITY)) u_wr_slot (
    .head_i (head_q),
    .pos_i  (wr_pos),
    .slot_o (wr_slot)
  );

  assign ram_waddr = waddr_head ? head_dec : wr_slot;

  dbs_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_slot),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if ((func_q == FUNC_CONTAINS || func_q == FUNC_REM_VALUE) && occ_q != '0) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RD_FRONT;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = (func_q == FUNC_REM_VALUE) ? ST_SHIFT : ST_RD_FRONT;
        end else if (idx_q >= occ_q) begin
          state_d = ST_RD_FRONT;
        end
      end
      ST_SHIFT: begin
        if (!pend_q && idx_q >= occ_q) state_d = ST_RD_FRONT;
      end
      ST_RD_FRONT: begin
        state_d = (occ_q == '0) ? ST_REPORT : ST_RD_BACK;
      end
      ST_RD_BACK: begin
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM controls and next values of the working registers.
  always_comb begin
    head_d     = head_q;
    occ_d      = occ_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    pend_d     = pend_q;
    status_d   = status_q;
    found_d    = found_q;
    front_d    = front_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    waddr_head = 1'b0;
    rd_pos     = idx_q;
    wr_pos     = wr_q;
    ram_wdata  = ram_rdata;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        status_d = STATUS_OK;
        found_d  = 1'b0;
      end
      ST_EXEC: begin
        idx_d  = '0;
        pend_d = 1'b0;
        case (func_q)
          FUNC_ADD_FRONT: begin
            if (occ_q == CAP_C) begin
              status_d = STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              waddr_head = 1'b1;
              ram_wdata  = val_q;
              head_d     = head_dec;
              occ_d      = occ_q + 1'b1;
            end
          end
          FUNC_ADD_BACK: begin
            if (occ_q == CAP_C) begin
              status_d = STATUS_FULL;
            end else begin
              ram_we    = 1'b1;
              wr_pos    = occ_q;
              ram_wdata = val_q;
              occ_d     = occ_q + 1'b1;
            end
          end
          FUNC_REM_FRONT, FUNC_REM_BACK: begin
            if (occ_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              occ_d = occ_q - 1'b1;
              if (func_q == FUNC_REM_FRONT) head_d = head_inc;
            end
          end
          FUNC_CONTAINS, FUNC_REM_VALUE: begin
            if (occ_q == '0) status_d = STATUS_EMPTY;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        // Reads are issued one per cycle; the compare looks at the entry
        // whose read was issued in the cycle before.
        if (match) begin
          found_d = 1'b1;
          wr_d    = idx_q - 1'b1;
          pend_d  = 1'b0;
        end else if (idx_q < occ_q) begin
          ram_re = 1'b1;
          rd_pos = idx_q;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_SHIFT: begin
        // Each later entry is read and written one place nearer the front
        // in the following cycle, so the read runs two places ahead.
        if (pend_q) begin
          ram_we = 1'b1;
          wr_pos = wr_q;
          wr_d   = wr_q + 1'b1;
        end
        if (idx_q < occ_q) begin
          ram_re = 1'b1;
          rd_pos = idx_q;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) occ_d = occ_q - 1'b1;
        end
      end
      ST_RD_FRONT: begin
        if (occ_q != '0) begin
          ram_re = 1'b1;
          rd_pos = '0;
        end
      end
      ST_RD_BACK: begin
        front_d = ram_rdata;
        ram_re  = 1'b1;
        rd_pos  = occ_q - 1'b1;
      end
      ST_REPORT: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      occ_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      val_q  <= val_in;
    end
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    status_q <= status_d;
    found_q  <= found_d;
    front_q  <= front_d;
    if (load_out) begin
      out_status_q <= status_q;
      out_found_q  <= found_q;
      out_empty_q  <= (occ_q == '0);
      out_count_q  <= occ_q;
      out_front_q  <= (occ_q == '0) ? '0 : front_ext;
      out_back_q   <= (occ_q == '0) ? '0 : back_ext;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign front_value_o = out_front_q;
  assign back_value_o  = out_back_q;
  assign is_empty_o    = out_empty_q;
  assign entry_count_o = out_count_q;

endmodule

/* hdl/dbs_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on dbs_pkg for its default sizes.
module dbs_ram #(
  parameter int WIDTH = dbs_pkg::DEF_VALUE_WIDTH,
  parameter int DEPTH = dbs_pkg::DEF_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/dbs_slot.sv */
// Maps a position counted from the front of the store to its buffer slot.
// Depends on dbs_pkg for the default capacity.
module dbs_slot #(
  parameter int CAPACITY = dbs_pkg::DEF_CAPACITY
) (
  input  logic [$clog2(CAPACITY)-1:0]   head_i,
  input  logic [$clog2(CAPACITY+1)-1:0] pos_i,
  output logic [$clog2(CAPACITY)-1:0]   slot_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] wrapped;

  // The head is below the capacity and the position is at most the capacity, so a single
  // compare and subtract is enough for the modulo.
  always_comb begin
    sum     = SUM_W'(head_i) + SUM_W'(pos_i);
    wrapped = (sum >= CAP_S) ? (sum - CAP_S) : sum;
    slot_o  = wrapped[IDX_W-1:0];
  end

endmodule
